@@ src/cvp_pkg.sv @@
// cvp_pkg: shared types and constants for the crossfade voice player
// holds the controller state enum, command and status structs, field widths
// no dependencies
package cvp_pkg;

    // payload widths
    localparam int SAMPLE_W = 16;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 17;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 16;

    // default voice memory depth in samples (power of two)
    localparam int VOICE_DEPTH_DEF = 65536;

    // fade divider: quotient width and step counter
    localparam int QUO_W     = 16;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    // crossfade length after reset
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(144);

    // saturation bounds
    localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -18'sd32768;

    // item modes
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_TAIL,
        ST_RD_VOICE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic trigger;
        logic read_start;
        logic rd_tail;
        logic rd_voice;
        logic mul;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tail_act;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

@@ src/cvp_ctrl.sv @@
// cvp_ctrl: sequencing state machine for load, trigger and read beats
// depends on cvp_pkg for the state enum and command/status structs
module cvp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cvp_pkg::MODE_W-1:0]    i_mode,
    input  cvp_pkg::t_status              i_status,
    output logic                          o_stall,
    output cvp_pkg::t_cmd                 o_cmd
);

    cvp_pkg::t_state r_state;
    cvp_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cvp_pkg::ST_IDLE: begin
                if (i_valid && i_mode == cvp_pkg::MODE_READ) begin
                    n_state = cvp_pkg::ST_RD_TAIL;
                end
            end
            cvp_pkg::ST_RD_TAIL:  n_state = cvp_pkg::ST_RD_VOICE;
            cvp_pkg::ST_RD_VOICE: n_state = cvp_pkg::ST_MUL;
            cvp_pkg::ST_MUL: begin
                n_state = i_status.tail_act ? cvp_pkg::ST_DIV : cvp_pkg::ST_DONE;
            end
            cvp_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = cvp_pkg::ST_DONE;
                end
            end
            cvp_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = cvp_pkg::ST_IDLE;
                end
            end
            default: n_state = cvp_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            cvp_pkg::ST_IDLE: begin
                o_stall          = 1'b0;
                o_cmd.load       = i_valid && i_mode == cvp_pkg::MODE_LOAD;
                o_cmd.trigger    = i_valid && i_mode == cvp_pkg::MODE_TRIGGER;
                o_cmd.read_start = i_valid && i_mode == cvp_pkg::MODE_READ;
            end
            cvp_pkg::ST_RD_TAIL:  o_cmd.rd_tail  = 1'b1;
            cvp_pkg::ST_RD_VOICE: o_cmd.rd_voice = 1'b1;
            cvp_pkg::ST_MUL:      o_cmd.mul      = 1'b1;
            cvp_pkg::ST_DIV:      o_cmd.div_step = 1'b1;
            cvp_pkg::ST_DONE:     o_cmd.finish   = i_status.out_free;
            default: o_stall = 1'b1;
        endcase
    end

endmodule

@@ src/cvp_datapath.sv @@
// cvp_datapath: voice memory, voice/tail pointers, fade multiply and divide,
// mix with saturation and the output register; depends on cvp_pkg
module cvp_datapath #(
    parameter int VOICE_DEPTH = cvp_pkg::VOICE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cvp_pkg::t_cmd                        i_cmd,
    output cvp_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic [cvp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [cvp_pkg::ADDR_W-1:0]           i_address,
    input  logic signed [cvp_pkg::SAMPLE_W-1:0]  i_data,
    input  logic [cvp_pkg::LEN_W-1:0]            i_length,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic signed [cvp_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                 o_sounding
);

    localparam int AW = $clog2(VOICE_DEPTH);
    // width wide enough for address input and cursor sums
    localparam int PA = (AW > cvp_pkg::ADDR_W) ? AW : cvp_pkg::ADDR_W;
    localparam int PW = (AW > cvp_pkg::LEN_W) ? AW : cvp_pkg::LEN_W;

    // voice memory
    logic [cvp_pkg::SAMPLE_W-1:0] r_mem [VOICE_DEPTH];
    logic [cvp_pkg::SAMPLE_W-1:0] r_rdata;

    // player state
    logic [cvp_pkg::CFG_W-1:0]    r_xfade_len;
    logic [AW-1:0]                r_voice_start;
    logic [cvp_pkg::LEN_W-1:0]    r_voice_length;
    logic [cvp_pkg::LEN_W-1:0]    r_voice_cursor;
    logic [AW-1:0]                r_tail_start;
    logic [cvp_pkg::CFG_W-1:0]    r_tail_length;
    logic [cvp_pkg::CFG_W-1:0]    r_tail_cursor;

    // per-read working registers
    logic                         r_tail_act;
    logic                         r_voice_act;
    logic [cvp_pkg::SAMPLE_W-1:0] r_tail_word;
    logic                         r_neg;
    logic [cvp_pkg::QUO_W-1:0]    r_rem;
    logic [cvp_pkg::QUO_W-1:0]    r_quo;
    logic [cvp_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic                         r_out_valid;
    logic [cvp_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                         r_out_sounding;

    logic [PA-1:0]                addr_ext;
    logic [PW:0]                  voice_sum;
    logic [PW:0]                  tail_sum;
    logic [AW-1:0]                voice_ptr;
    logic [AW-1:0]                tail_ptr;
    logic [AW-1:0]                rd_addr;
    logic                         voice_left;
    logic                         tail_left;
    logic [cvp_pkg::LEN_W-1:0]    rest;
    logic [cvp_pkg::CFG_W-1:0]    new_tail_len;
    logic [cvp_pkg::SAMPLE_W-1:0] tail_mag;
    logic [cvp_pkg::CFG_W-1:0]    fade_weight;
    logic [2*cvp_pkg::QUO_W-1:0]  product;
    logic [cvp_pkg::QUO_W:0]      trial;
    logic [cvp_pkg::QUO_W:0]      trial_diff;
    logic                         q_bit;
    logic signed [cvp_pkg::SAMPLE_W+1:0] fade_term;
    logic signed [cvp_pkg::SAMPLE_W+1:0] voice_term;
    logic signed [cvp_pkg::SAMPLE_W+1:0] mix;
    logic [cvp_pkg::SAMPLE_W-1:0] mix_sat;
    logic                         out_free;

    // memory addresses wrap at the power-of-two depth
    assign addr_ext  = PA'(i_address);
    assign voice_sum = (PW+1)'(r_voice_start) + (PW+1)'(r_voice_cursor);
    assign tail_sum  = (PW+1)'(r_tail_start) + (PW+1)'(r_tail_cursor);
    assign voice_ptr = voice_sum[AW-1:0];
    assign tail_ptr  = tail_sum[AW-1:0];
    assign rd_addr   = i_cmd.rd_tail ? tail_ptr : voice_ptr;

    // memory write on load, registered read for the sequencer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[addr_ext[AW-1:0]] <= i_data;
        end
        if (i_cmd.rd_tail || i_cmd.rd_voice) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // remaining old voice becomes the tail, capped at the crossfade length
    assign voice_left   = r_voice_cursor < r_voice_length;
    assign tail_left    = r_tail_cursor < r_tail_length;
    assign rest         = r_voice_length - r_voice_cursor;
    assign new_tail_len = (rest > cvp_pkg::LEN_W'(r_xfade_len)) ? r_xfade_len
                                                                 : rest[cvp_pkg::CFG_W-1:0];

    // config and player state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfade_len    <= cvp_pkg::CFG_RESET;
            r_voice_start  <= '0;
            r_voice_length <= '0;
            r_voice_cursor <= '0;
            r_tail_start   <= '0;
            r_tail_length  <= '0;
            r_tail_cursor  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_xfade_len <= i_cfg_data;
            end
            if (i_cmd.trigger) begin
                if (r_xfade_len != '0 && voice_left) begin
                    r_tail_start  <= voice_ptr;
                    r_tail_length <= new_tail_len;
                end else begin
                    r_tail_length <= '0;
                end
                r_tail_cursor  <= '0;
                r_voice_start  <= addr_ext[AW-1:0];
                r_voice_length <= i_length;
                r_voice_cursor <= '0;
            end
            if (i_cmd.finish) begin
                if (r_tail_act) begin
                    r_tail_cursor <= r_tail_cursor + 1'b1;
                end
                if (r_voice_act) begin
                    r_voice_cursor <= r_voice_cursor + 1'b1;
                end
            end
        end
    end

    // fade multiply: |tail| * (len - pos)
    assign tail_mag    = r_tail_word[cvp_pkg::SAMPLE_W-1] ? (~r_tail_word + 1'b1) : r_tail_word;
    assign fade_weight = r_tail_length - r_tail_cursor;
    assign product     = (2*cvp_pkg::QUO_W)'(tail_mag) * (2*cvp_pkg::QUO_W)'(fade_weight);

    // one restoring divide step per cycle; quotient stays below 2^16
    assign trial      = {r_rem, r_quo[cvp_pkg::QUO_W-1]};
    assign trial_diff = trial - (cvp_pkg::QUO_W+1)'(r_tail_length);
    assign q_bit      = trial >= (cvp_pkg::QUO_W+1)'(r_tail_length);

    // read working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_start) begin
            r_tail_act  <= tail_left;
            r_voice_act <= voice_left;
        end
        if (i_cmd.rd_voice) begin
            r_tail_word <= r_rdata;
        end
        if (i_cmd.mul) begin
            r_rem     <= product[2*cvp_pkg::QUO_W-1:cvp_pkg::QUO_W];
            r_quo     <= product[cvp_pkg::QUO_W-1:0];
            r_neg     <= r_tail_word[cvp_pkg::SAMPLE_W-1];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= q_bit ? trial_diff[cvp_pkg::QUO_W-1:0] : trial[cvp_pkg::QUO_W-1:0];
            r_quo     <= {r_quo[cvp_pkg::QUO_W-2:0], q_bit};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // mix tail term with voice sample and saturate
    always_comb begin
        fade_term = '0;
        if (r_tail_act) begin
            fade_term = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
        end
        voice_term = r_voice_act ? (cvp_pkg::SAMPLE_W+2)'($signed(r_rdata)) : '0;
        mix        = fade_term + voice_term;
        priority if (mix > cvp_pkg::SAT_MAX) begin
            mix_sat = cvp_pkg::SAT_MAX[cvp_pkg::SAMPLE_W-1:0];
        end else if (mix < cvp_pkg::SAT_MIN) begin
            mix_sat = cvp_pkg::SAT_MIN[cvp_pkg::SAMPLE_W-1:0];
        end else begin
            mix_sat = mix[cvp_pkg::SAMPLE_W-1:0];
        end
    end

    // output register holds a beat until taken
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_sample   <= mix_sat;
            r_out_sounding <= r_tail_act || r_voice_act;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_sample   = r_out_sample;
    assign o_sounding = r_out_sounding;

    // status to controller
    assign o_status.tail_act = r_tail_act;
    assign o_status.div_last = r_div_cnt == cvp_pkg::DIV_LAST;
    assign o_status.out_free = out_free;

endmodule

@@ src/crossfade_voice_player_core.sv @@
// crossfade_voice_player_core: one-shot voice player with crossfading tail
// load and trigger beats are taken in idle; a read beat steps through tail read,
// voice read, multiply, the bit-serial fade divider (only with a tail sounding) and done,
// where it waits for the output register to drain. depends on cvp_pkg.
// reset (synchronous, active low) clears control, sets crossfade length to 144;
// voice memory is not cleared and holds garbage until loaded
module crossfade_voice_player_core #(
    parameter int VOICE_DEPTH = cvp_pkg::VOICE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cvp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cvp_pkg::MODE_W-1:0]           i_mode,
    input  logic [cvp_pkg::ADDR_W-1:0]           i_address,
    input  logic signed [cvp_pkg::SAMPLE_W-1:0]  i_data,
    input  logic [cvp_pkg::LEN_W-1:0]            i_length,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [cvp_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                 o_sounding
);

    cvp_pkg::t_cmd    cmd;
    cvp_pkg::t_status status;

    // sequencer
    cvp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // memory, arithmetic and output register
    cvp_datapath #(
        .VOICE_DEPTH (VOICE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_address  (i_address),
        .i_data     (i_data),
        .i_length   (i_length),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_sample   (o_sample),
        .o_sounding (o_sounding)
    );

endmodule

@@ tb/testbench.sv @@
// testbench for crossfade_voice_player_core: loads, triggers, reads and register writes
// predicts every output sample in a self-contained player model; depends on cvp_pkg
module testbench;

    localparam int MODE_W   = cvp_pkg::MODE_W;
    localparam int ADDR_W   = cvp_pkg::ADDR_W;
    localparam int SAMPLE_W = cvp_pkg::SAMPLE_W;
    localparam int LEN_W    = cvp_pkg::LEN_W;
    localparam int CFG_W    = cvp_pkg::CFG_W;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int DEPTH     = cvp_pkg::VOICE_DEPTH_DEF;
    localparam int LONG_HOLD = 200;
    localparam int SETTLE    = 40;
    localparam int SHOW_MAX  = 10;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
        logic [LEN_W-1:0]           len;
        bit                         makes_sample;
        logic signed [SAMPLE_W-1:0] want_sample;
        logic                       want_sounding;
    } t_beat;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sounding;
    } t_mix;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_valid    = 1'b0;
    logic                       o_stall;
    logic [MODE_W-1:0]          i_mode     = '0;
    logic [ADDR_W-1:0]          i_address  = '0;
    logic signed [SAMPLE_W-1:0] i_data     = '0;
    logic [LEN_W-1:0]           i_length   = '0;
    logic                       o_valid;
    logic                       i_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_sounding;

    crossfade_voice_player_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_address  (i_address),
        .i_data     (i_data),
        .i_length   (i_length),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sample   (o_sample),
        .o_sounding (o_sounding)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // beats waiting to be sent, samples waiting to come out
    t_beat pend_q[$];
    t_mix  sample_q[$];

    // player copy: voice memory, voice and fading tail
    logic signed [SAMPLE_W-1:0] shadow_mem [DEPTH];
    bit                         loaded [DEPTH];
    logic [CFG_W-1:0]           fade_len   = cvp_pkg::CFG_RESET;
    logic [ADDR_W-1:0]          voice_base = '0;
    logic [LEN_W-1:0]           voice_len  = '0;
    logic [LEN_W-1:0]           voice_pos  = '0;
    logic [ADDR_W-1:0]          tail_base  = '0;
    logic [LEN_W-1:0]           tail_len   = '0;
    logic [LEN_W-1:0]           tail_pos   = '0;

    bit rst_done     = 1'b0;
    bit beat_done    = 1'b0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int fail_cnt     = 0;
    int shown        = 0;
    int beats_taken  = 0;
    int samples_seen = 0;
    int settings_cnt = 0;
    int offered      = 0;

    // advance the player by one beat and fill in the sample it produces
    function automatic t_beat play_beat(input t_beat b);
        t_beat            r;
        logic [LEN_W-1:0] rest;
        logic [ADDR_W-1:0] at;
        longint           mix;
        r = b;
        r.makes_sample  = 1'b0;
        r.want_sample   = '0;
        r.want_sounding = 1'b0;
        case (b.mode)
            cvp_pkg::MODE_LOAD: begin
                shadow_mem[b.addr] = b.data;
                loaded[b.addr] = 1'b1;
            end
            cvp_pkg::MODE_TRIGGER: begin
                // unplayed rest of the old voice fades, capped at the crossfade length
                if (fade_len != '0 && voice_pos < voice_len) begin
                    rest = voice_len - voice_pos;
                    tail_base = voice_base + voice_pos[ADDR_W-1:0];
                    tail_len = (rest > LEN_W'(fade_len)) ? LEN_W'(fade_len) : rest;
                end else begin
                    tail_len = '0;
                end
                tail_pos   = '0;
                voice_base = b.addr;
                voice_len  = b.len;
                voice_pos  = '0;
            end
            cvp_pkg::MODE_READ: begin
                mix = 0;
                if (tail_pos < tail_len) begin
                    // linear fade, truncated toward zero, plus the voice if it runs
                    at = tail_base + tail_pos[ADDR_W-1:0];
                    mix = (longint'(shadow_mem[at]) * longint'(tail_len - tail_pos))
                        / longint'(tail_len);
                    if (voice_pos < voice_len) begin
                        at = voice_base + voice_pos[ADDR_W-1:0];
                        mix += longint'(shadow_mem[at]);
                        voice_pos++;
                    end
                    tail_pos++;
                    r.want_sounding = 1'b1;
                end else if (voice_pos < voice_len) begin
                    at = voice_base + voice_pos[ADDR_W-1:0];
                    mix = longint'(shadow_mem[at]);
                    voice_pos++;
                    r.want_sounding = 1'b1;
                end
                if (mix > longint'(cvp_pkg::SAT_MAX)) mix = longint'(cvp_pkg::SAT_MAX);
                if (mix < longint'(cvp_pkg::SAT_MIN)) mix = longint'(cvp_pkg::SAT_MIN);
                r.want_sample  = SAMPLE_W'(mix);
                r.makes_sample = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // queue one beat, predicting in send order
    task automatic offer(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                         input logic signed [SAMPLE_W-1:0] data,
                         input logic [LEN_W-1:0] len);
        t_beat b;
        b.mode = mode;
        b.addr = addr;
        b.data = data;
        b.len  = len;
        b.makes_sample  = 1'b0;
        b.want_sample   = '0;
        b.want_sounding = 1'b0;
        pend_q.push_back(play_beat(b));
        offered++;
    endtask

    // read beat; first load any word it would touch that was never written
    task automatic read_once();
        logic [ADDR_W-1:0] at;
        if (tail_pos < tail_len) begin
            at = tail_base + tail_pos[ADDR_W-1:0];
            if (!loaded[at]) offer(cvp_pkg::MODE_LOAD, at, SAMPLE_W'($urandom),
                                   LEN_W'($urandom_range(0, 65536)));
        end
        if (voice_pos < voice_len) begin
            at = voice_base + voice_pos[ADDR_W-1:0];
            if (!loaded[at]) offer(cvp_pkg::MODE_LOAD, at, SAMPLE_W'($urandom),
                                   LEN_W'($urandom_range(0, 65536)));
        end
        offer(cvp_pkg::MODE_READ, ADDR_W'($urandom), SAMPLE_W'($urandom),
              LEN_W'($urandom_range(0, 65536)));
    endtask

    // mostly short voices, some silent, some long up to full depth
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2) return '0;
        if (r < 4) return LEN_W'($urandom_range(49, 65536));
        if (r == 4) return LEN_W'(65536);
        return LEN_W'($urandom_range(1, 48));
    endfunction

    // trigger followed by a run of reads, with stray beats and noise mixed in
    task automatic random_run(input int n);
        int start;
        int pick;
        start = offered;
        while (offered - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                offer(MODE_SPARE, ADDR_W'($urandom), SAMPLE_W'($urandom),
                      LEN_W'($urandom_range(0, 65536)));
            end else if (pick < 10) begin
                read_once();
            end else if (pick < 13) begin
                offer(cvp_pkg::MODE_LOAD, ADDR_W'($urandom), SAMPLE_W'($urandom),
                      LEN_W'($urandom_range(0, 65536)));
            end else if (pick < 17) begin
                // trigger cut short by the next one
                offer(cvp_pkg::MODE_TRIGGER, ADDR_W'($urandom), SAMPLE_W'($urandom),
                      pick_length());
            end else begin
                offer(cvp_pkg::MODE_TRIGGER, ADDR_W'($urandom), SAMPLE_W'($urandom),
                      pick_length());
                repeat ($urandom_range(1, 24)) begin
                    if ($urandom_range(0, 5) == 0) begin
                        // overwrite a word of the running voice at or just ahead of the cursor
                        offer(cvp_pkg::MODE_LOAD, voice_base + voice_pos[ADDR_W-1:0]
                              + ADDR_W'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                              LEN_W'($urandom_range(0, 65536)));
                    end
                    read_once();
                end
            end
        end
    endtask

    // wait until every queued beat is sent and every sample has come out
    task automatic drain();
        while (pend_q.size() != 0 || sample_q.size() != 0 || i_valid) @(negedge i_clk);
    endtask

    // register write while the block is idle
    task automatic set_fade(input logic [CFG_W-1:0] v);
        drain();
        // a load or trigger may still be finishing inside
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        fade_len = v;
        settings_cnt++;
    endtask

    // beat acceptance: release the prediction of the beat just taken
    always @(posedge i_clk) begin : take_beat
        t_mix m;
        if (i_valid && !o_stall) begin
            if (pend_q[0].makes_sample) begin
                m.sample   = pend_q[0].want_sample;
                m.sounding = pend_q[0].want_sounding;
                sample_q.push_back(m);
            end
            void'(pend_q.pop_front());
            beats_taken++;
            beat_done = 1'b1;
        end
    end

    // sender: hold a beat until taken, random gaps between beats
    always @(negedge i_clk) begin
        if (!i_valid || beat_done) begin
            beat_done = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (rst_done && pend_q.size() > 0) begin
                i_valid   <= 1'b1;
                i_mode    <= pend_q[0].mode;
                i_address <= pend_q[0].addr;
                i_data    <= pend_q[0].data;
                i_length  <= pend_q[0].len;
                gap_left = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: short stall bursts, one long hold on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
        end
    end

    // output check against the oldest predicted sample
    always @(posedge i_clk) begin : check_sample
        t_mix w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sample_q.size() == 0) begin
                fail_cnt++;
                if (shown < SHOW_MAX)
                    $display("tb: unexpected sample %0d sounding %0d", o_sample, o_sounding);
                shown++;
            end else begin
                w = sample_q.pop_front();
                samples_seen++;
                if (o_sample !== w.sample || o_sounding !== w.sounding) begin
                    fail_cnt++;
                    if (shown < SHOW_MAX)
                        $display("tb: mismatch sample exp %0d got %0d, sounding exp %0d got %0d",
                                 w.sample, o_sample, w.sounding, o_sounding);
                    shown++;
                end
            end
        end
    end

    // stimulus phases
    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // silent read after reset, ignored mode with every field bit set
        read_once();
        offer(MODE_SPARE, 16'hFFFF, -16'sd1, 17'h1FFFF);
        // data extremes, voice wrapping past the top of memory
        offer(cvp_pkg::MODE_LOAD, 16'hFFFF, 16'sd32767, '0);
        offer(cvp_pkg::MODE_LOAD, 16'h0000, -16'sd32768, 17'h10000);
        offer(cvp_pkg::MODE_LOAD, 16'h0001, 16'sd0, '0);
        offer(cvp_pkg::MODE_TRIGGER, 16'hFFFF, '0, 17'd3);
        read_once();
        // silent voice over a fading tail
        offer(cvp_pkg::MODE_TRIGGER, 16'h0000, '0, 17'd0);
        read_once();
        read_once();
        read_once();
        // positive saturation of tail plus voice
        offer(cvp_pkg::MODE_LOAD, 16'd10, 16'sd32767, '0);
        offer(cvp_pkg::MODE_LOAD, 16'd11, 16'sd32767, '0);
        offer(cvp_pkg::MODE_TRIGGER, 16'd10, '0, 17'd2);
        read_once();
        offer(cvp_pkg::MODE_TRIGGER, 16'd10, '0, 17'd2);
        read_once();
        // negative saturation
        offer(cvp_pkg::MODE_LOAD, 16'd20, -16'sd32768, '0);
        offer(cvp_pkg::MODE_LOAD, 16'd21, -16'sd32768, '0);
        offer(cvp_pkg::MODE_TRIGGER, 16'd20, '0, 17'd2);
        read_once();
        offer(cvp_pkg::MODE_TRIGGER, 16'd20, '0, 17'd2);
        read_once();
        // full-depth voice, loaded after its trigger, then a capped tail
        offer(cvp_pkg::MODE_TRIGGER, 16'h8000, '0, 17'h10000);
        offer(cvp_pkg::MODE_LOAD, 16'h8000, 16'sh1234, '0);
        read_once();
        offer(cvp_pkg::MODE_TRIGGER, 16'h7FFF, '0, 17'hFFFF);
        read_once();
        random_run(100);

        set_fade('0);
        hold_request = 1'b1;
        random_run(100);

        set_fade(16'hFFFF);
        random_run(50);
        drain();
        random_run(50);

        set_fade(16'd1);
        random_run(100);

        set_fade(CFG_W'($urandom_range(2, 64)));
        random_run(100);

        set_fade(16'd3);
        calm = 1'b1;
        random_run(100);

        drain();
        repeat (SETTLE) @(negedge i_clk);
        fail_cnt += sample_q.size();

        $display("tb: %0d beats taken, %0d samples checked over %0d crossfade settings",
                 beats_taken, samples_seen, settings_cnt);
        $display("tb: fades, silent voices, saturation, wrap, live loads and long stalls run");
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
src/cvp_pkg.sv
src/cvp_ctrl.sv
src/cvp_datapath.sv
src/crossfade_voice_player_core.sv
tb/testbench.sv
